>>> hw/rtl/bmmd_pkg.sv
// Shared constants, types and address-decode helpers for the banked memory map decoder.
package bmmd_pkg;

   localparam int unsigned DEF_WORK_RAM_BANKS  = 8;
   localparam int unsigned DEF_VIDEO_RAM_BANKS = 2;

   localparam int unsigned WRAM_BANK_BYTES = 32'h1000;
   localparam int unsigned VRAM_BANK_BYTES = 32'h2000;

   localparam logic [15:0] ADDR_IF    = 16'hFF0F;
   localparam logic [15:0] ADDR_IE    = 16'hFFFF;
   localparam logic [15:0] ADDR_KEY1  = 16'hFF4D;
   localparam logic [15:0] ADDR_SVBK  = 16'hFF70;
   localparam logic [15:0] ADDR_FIXED = 16'hFF56;

   localparam logic [7:0] FIXED_READ_VALUE = 8'hFF;

   typedef enum logic [2:0] {
      TGT_LOCAL   = 3'd0,
      TGT_CART    = 3'd1,
      TGT_JOYPAD  = 3'd2,
      TGT_SERIAL  = 3'd3,
      TGT_DIVIDER = 3'd4,
      TGT_TIMER   = 3'd5,
      TGT_AUDIO   = 3'd6,
      TGT_VIDEO   = 3'd7
   } target_type;

   // Where the read byte of a beat in flight comes from.
   typedef enum logic [2:0] {
      SRC_REG  = 3'd0,
      SRC_WRAM = 3'd1,
      SRC_VRAM = 3'd2,
      SRC_FE   = 3'd3,
      SRC_HRAM = 3'd4
   } source_type;

   function automatic target_type decode_target(input logic [15:0] addr);
      target_type t;
      t = TGT_LOCAL;
      if (addr inside {[16'h0000:16'h7FFF], [16'hA000:16'hBFFF]}) begin
         t = TGT_CART;
      end else if (addr == 16'hFF00) begin
         t = TGT_JOYPAD;
      end else if (addr inside {16'hFF01, 16'hFF02}) begin
         t = TGT_SERIAL;
      end else if (addr == 16'hFF04) begin
         t = TGT_DIVIDER;
      end else if (addr inside {[16'hFF05:16'hFF07]}) begin
         t = TGT_TIMER;
      end else if (addr inside {[16'hFF10:16'hFF3F]}) begin
         t = TGT_AUDIO;
      end else if (addr inside {[16'hFF40:16'hFF4B], 16'hFF4F, [16'hFF51:16'hFF55],
                                [16'hFF68:16'hFF6B]}) begin
         t = TGT_VIDEO;
      end
      return t;
   endfunction

endpackage

>>> hw/rtl/banked_memory_map_decoder.sv
// Banked memory map decoder: address decode, local RAMs and system registers.
// A request beat is registered in the decode stage and then in the output register, where
// rsp_tvalid rises; a stall on rsp_tready can hold the beat in either stage.
// Throughput: one access per cycle while rsp_tready is high; each memory has one port.
// Reset clears the pipeline valids and the system registers (bank select to 1);
// the RAMs are not cleared and hold unspecified data until written.
module banked_memory_map_decoder #(
   parameter int unsigned WORK_RAM_BANKS  = bmmd_pkg::DEF_WORK_RAM_BANKS,
   parameter int unsigned VIDEO_RAM_BANKS = bmmd_pkg::DEF_VIDEO_RAM_BANKS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] address, [23:16] write_data, [24] vram_bank
   input  logic        req_tuser,   // [0] mode (0 read, 1 write)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] read_data
   output logic [2:0]  rsp_tuser    // [2:0] target
);
   import bmmd_pkg::*;

   localparam int unsigned WRAM_DEPTH = WORK_RAM_BANKS * WRAM_BANK_BYTES;
   localparam int unsigned VRAM_DEPTH = VIDEO_RAM_BANKS * VRAM_BANK_BYTES;
   localparam int unsigned WRAM_AW    = $clog2(WRAM_DEPTH);
   localparam int unsigned VRAM_AW    = $clog2(VRAM_DEPTH);

   // Request beat fields.
   logic        req_mode;
   logic [15:0] req_address;
   logic [7:0]  req_write_data;
   logic        req_vram_bank;

   assign req_mode       = req_tuser;
   assign req_address    = req_tdata[15:0];
   assign req_write_data = req_tdata[23:16];
   assign req_vram_bank  = req_tdata[24];

   // The four local memories. Object RAM and the unusable area share the FE page.
   logic [7:0] wram [WRAM_DEPTH];
   logic [7:0] vram [VRAM_DEPTH];
   logic [7:0] fe_ram [256];
   logic [7:0] hram [128];

   logic [7:0] wram_q_ff, vram_q_ff, fe_q_ff, hram_q_ff;

   // System registers.
   logic [7:0] ie_ff, ie_in;
   logic [7:0] if_ff, if_in;
   logic [7:0] speed_ff, speed_in;
   logic [2:0] work_bank_ff, work_bank_in;

   // Decode stage: one beat whose memory read is in flight.
   logic       s1_valid_ff, s1_valid_in;
   target_type s1_target_ff;
   source_type s1_source_ff;
   logic [7:0] s1_reg_data_ff;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   target_type rsp_target_ff;
   logic [7:0] rsp_data_ff;

   logic s1_move;
   logic accept;

   // The decode stage empties into the output register when that register is
   // free or its beat is being taken this cycle. A new request enters only when
   // the decode stage is empty or empties, so the RAM read registers hold while it stalls.
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   // Address decode of the request beat.
   target_type    tgt;
   source_type    src;
   logic [7:0]    reg_rd;
   logic          is_wram, is_vram, is_fe, is_hram;
   logic [3:0]    bank_mod;
   logic [WRAM_AW-1:0] wram_idx;
   logic [VRAM_AW-1:0] vram_idx;
   logic          vbank;

   always_comb begin
      tgt     = decode_target(req_address);
      is_vram = (tgt == TGT_LOCAL) && (req_address inside {[16'h8000:16'h9FFF]});
      is_wram = (tgt == TGT_LOCAL) && (req_address inside {[16'hC000:16'hFDFF]});
      is_fe   = (tgt == TGT_LOCAL) && (req_address inside {[16'hFE00:16'hFEFF]});
      is_hram = (tgt == TGT_LOCAL) && (req_address inside {[16'hFF80:16'hFFFE]});

      // Switchable bank reduced modulo the bank count; the bank select is below
      // eight and the count must be at least two, which is not checked here, so three compare-subtract steps suffice.
      bank_mod = {1'b0, work_bank_ff};
      for (int i = 0; i < 3; i++) begin
         if (bank_mod >= 4'(WORK_RAM_BANKS)) begin
            bank_mod = bank_mod - 4'(WORK_RAM_BANKS);
         end
      end
      if (req_address[12]) begin
         wram_idx = WRAM_AW'(32'(bank_mod) * WRAM_BANK_BYTES + 32'(req_address[11:0]));
      end else begin
         wram_idx = WRAM_AW'(req_address[11:0]);
      end

      vbank    = (VIDEO_RAM_BANKS > 1) ? req_vram_bank : 1'b0;
      vram_idx = VRAM_AW'(32'(vbank) * VRAM_BANK_BYTES + 32'(req_address[12:0]));

      // Source of the read byte; register reads are resolved here.
      src    = SRC_REG;
      reg_rd = '0;
      if (is_wram) begin
         src = SRC_WRAM;
      end else if (is_vram) begin
         src = SRC_VRAM;
      end else if (is_fe) begin
         src = SRC_FE;
      end else if (is_hram) begin
         src = SRC_HRAM;
      end else if (tgt == TGT_LOCAL) begin
         case (req_address)
            ADDR_IF:    reg_rd = if_ff;
            ADDR_IE:    reg_rd = ie_ff;
            ADDR_KEY1:  reg_rd = speed_ff;
            ADDR_SVBK:  reg_rd = {5'd0, work_bank_ff};
            ADDR_FIXED: reg_rd = FIXED_READ_VALUE;
            default:    reg_rd = '0;
         endcase
      end
      // Writes return zero whatever the source.
      if (req_mode) begin
         src    = SRC_REG;
         reg_rd = '0;
      end
   end

   // System register updates on accepted write beats.
   always_comb begin
      ie_in        = ie_ff;
      if_in        = if_ff;
      speed_in     = speed_ff;
      work_bank_in = work_bank_ff;
      if (accept && req_mode && (tgt == TGT_LOCAL)) begin
         case (req_address)
            ADDR_IF:   if_in    = req_write_data;
            ADDR_IE:   ie_in    = req_write_data;
            ADDR_KEY1: speed_in = req_write_data;
            ADDR_SVBK: begin
               // Selecting bank zero selects bank one.
               work_bank_in = (req_write_data[2:0] == 3'd0) ? 3'd1 : req_write_data[2:0];
            end
            default: ;
         endcase
      end
   end

   // Memories: one write or one read per cycle each on accepted beats, read data registered.
   always_ff @(posedge clock) begin
      if (accept && is_wram) begin
         if (req_mode) begin
            wram[wram_idx] <= req_write_data;
         end else begin
            wram_q_ff <= wram[wram_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_vram) begin
         if (req_mode) begin
            vram[vram_idx] <= req_write_data;
         end else begin
            vram_q_ff <= vram[vram_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_fe) begin
         if (req_mode) begin
            fe_ram[req_address[7:0]] <= req_write_data;
         end else begin
            fe_q_ff <= fe_ram[req_address[7:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_hram) begin
         if (req_mode) begin
            hram[req_address[6:0]] <= req_write_data;
         end else begin
            hram_q_ff <= hram[req_address[6:0]];
         end
      end
   end

   // Pipeline valids.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ie_ff        <= '0;
         if_ff        <= '0;
         speed_ff     <= '0;
         work_bank_ff <= 3'd1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ie_ff        <= ie_in;
         if_ff        <= if_in;
         speed_ff     <= speed_in;
         work_bank_ff <= work_bank_in;
      end
   end

   // Payload of the decode stage and the output register.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_target_ff   <= tgt;
         s1_source_ff   <= src;
         s1_reg_data_ff <= reg_rd;
      end
      if (s1_move) begin
         rsp_target_ff <= s1_target_ff;
         case (s1_source_ff)
            SRC_WRAM: rsp_data_ff <= wram_q_ff;
            SRC_VRAM: rsp_data_ff <= vram_q_ff;
            SRC_FE:   rsp_data_ff <= fe_q_ff;
            SRC_HRAM: rsp_data_ff <= hram_q_ff;
            default:  rsp_data_ff <= s1_reg_data_ff;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_target_ff;

endmodule

>>> tb/banked_memory_map_decoder_checker.sv
// Bus access checker for the banked memory map decoder: predicts each result beat and compares.
`timescale 1ns / 1ps

module banked_memory_map_decoder_checker #(
   parameter int unsigned WORK_RAM_BANKS  = bmmd_pkg::DEF_WORK_RAM_BANKS,
   parameter int unsigned VIDEO_RAM_BANKS = bmmd_pkg::DEF_VIDEO_RAM_BANKS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] address, [23:16] write_data, [24] vram_bank
   input  logic        req_tuser,   // [0] mode (0 read, 1 write)
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] read_data
   input  logic [2:0]  rsp_tuser,   // [2:0] target
   output int          mismatch_count,
   output int          results_pending
);

   import bmmd_pkg::*;

   typedef struct {
      logic [15:0] address;
      logic        write;
      target_type  target;
      logic [7:0]  read_data;
   } bus_result_type;

   // Shadow copies of every store the decoder serves locally.
   logic [7:0] wram_copy [WORK_RAM_BANKS * WRAM_BANK_BYTES];
   logic [7:0] vram_copy [VIDEO_RAM_BANKS * VRAM_BANK_BYTES];
   logic [7:0] fe_page_copy [256];   // object RAM followed by the unusable area
   logic [7:0] hram_copy [128];
   logic [7:0] ie_copy;
   logic [7:0] if_copy;
   logic [7:0] speed_copy;
   logic [2:0] bank_sel_copy;

   bus_result_type awaited_results[$];
   int             mismatches = 0;

   function automatic target_type unit_at(input logic [15:0] a);
      logic [7:0] io;
      io = a[7:0];
      if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) return TGT_CART;
      if (a[15:8] != 8'hFF) return TGT_LOCAL;
      if (io == 8'h00) return TGT_JOYPAD;
      if (io == 8'h01 || io == 8'h02) return TGT_SERIAL;
      if (io == 8'h04) return TGT_DIVIDER;
      if (io >= 8'h05 && io <= 8'h07) return TGT_TIMER;
      if (io >= 8'h10 && io <= 8'h3F) return TGT_AUDIO;
      if ((io >= 8'h40 && io <= 8'h4B) || io == 8'h4F || (io >= 8'h51 && io <= 8'h55) ||
          (io >= 8'h68 && io <= 8'h6B)) return TGT_VIDEO;
      return TGT_LOCAL;
   endfunction

   // Applies one access to the shadow state and returns the beat it should produce.
   function automatic bus_result_type predict_access(input logic wr, input logic [15:0] a,
                                                     input logic [7:0] d, input logic vb);
      bus_result_type r;
      int unsigned idx;
      r.address   = a;
      r.write     = wr;
      r.target    = unit_at(a);
      r.read_data = '0;
      if (r.target == TGT_LOCAL) begin
         if (a >= 16'h8000 && a <= 16'h9FFF) begin
            idx = (int'(vb) % VIDEO_RAM_BANKS) * VRAM_BANK_BYTES + a[12:0];
            if (wr) vram_copy[idx] = d; else r.read_data = vram_copy[idx];
         end else if (a >= 16'hC000 && a <= 16'hFDFF) begin
            // Bit 12 picks the switchable half; the echo area shares the same cells.
            idx = a[11:0];
            if (a[12]) begin
               idx += (int'(bank_sel_copy) % WORK_RAM_BANKS) * WRAM_BANK_BYTES;
            end
            if (wr) wram_copy[idx] = d; else r.read_data = wram_copy[idx];
         end else if (a[15:8] == 8'hFE) begin
            if (wr) fe_page_copy[a[7:0]] = d; else r.read_data = fe_page_copy[a[7:0]];
         end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
            if (wr) hram_copy[a[6:0]] = d; else r.read_data = hram_copy[a[6:0]];
         end else if (a == ADDR_IF) begin
            if (wr) if_copy = d; else r.read_data = if_copy;
         end else if (a == ADDR_IE) begin
            if (wr) ie_copy = d; else r.read_data = ie_copy;
         end else if (a == ADDR_KEY1) begin
            if (wr) speed_copy = d; else r.read_data = speed_copy;
         end else if (a == ADDR_SVBK) begin
            if (wr) bank_sel_copy = (d[2:0] == 3'd0) ? 3'd1 : d[2:0];
            else r.read_data = {5'd0, bank_sel_copy};
         end else if (a == ADDR_FIXED) begin
            if (!wr) r.read_data = FIXED_READ_VALUE;
         end
      end
      if (wr) r.read_data = '0;
      return r;
   endfunction

   always @(posedge clock) begin
      bus_result_type want;
      if (reset) begin
         ie_copy       = '0;
         if_copy       = '0;
         speed_copy    = '0;
         bank_sel_copy = 3'd1;
         awaited_results.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(predict_access(req_tuser, req_tdata[15:0],
                                                     req_tdata[23:16], req_tdata[24]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with no access outstanding, target %0d data %02h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tuser !== want.target) begin
                  mismatches++;
                  $display("%0t: target for %s %04h expected %0d, got %0d", $time,
                           want.write ? "write" : "read", want.address, want.target,
                           rsp_tuser);
               end
               if (rsp_tdata !== want.read_data) begin
                  mismatches++;
                  $display("%0t: read_data for %s %04h expected %02h, got %02h", $time,
                           want.write ? "write" : "read", want.address, want.read_data,
                           rsp_tdata);
               end
            end
         end
      end
      mismatch_count  <= mismatches;
      results_pending <= awaited_results.size();
   end

endmodule

>>> tb/banked_memory_map_decoder_tb.sv
// Top of the banked memory map decoder testbench: clock, reset, bus stimulus and verdict.
`timescale 1ns / 1ps

module banked_memory_map_decoder_tb;

   import bmmd_pkg::*;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [15:0] address, [23:16] write_data, [24] vram_bank
   logic        req_tuser  = 1'b0; // [0] mode (0 read, 1 write)
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] read_data
   logic [2:0]  rsp_tuser;         // [2:0] target

   int mismatch_count;
   int results_pending;

   // Percentages of cycles in which the sender holds back a beat and the receiver stalls.
   int unsigned send_idle_pct = 32;
   int unsigned recv_idle_pct = 57;

   // The stimulus must never read a RAM byte that was not written first. Every written
   // cell is remembered by a key that names its physical location, so bank switching
   // and the echo area are accounted for. The bank select is mirrored here for that.
   bit          written_cells[int];
   logic [16:0] written_spots[$];  // {vram_bank, address} of recent writes, for read-back
   logic [2:0]  bank_shadow = 3'd1;

   banked_memory_map_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   banked_memory_map_decoder_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver decides afresh at every falling edge whether it takes a result beat.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Returns a key for the RAM byte that an access touches, or -1 when it touches none.
   function automatic int ram_cell_key(input logic [15:0] addr, input logic vb);
      int bank;
      if (addr >= 16'h8000 && addr <= 16'h9FFF) begin
         return int'(addr[12:0]) + (int'(vb) % int'(DEF_VIDEO_RAM_BANKS)) * 'h2000;
      end
      if (addr >= 16'hC000 && addr <= 16'hFDFF) begin
         bank = addr[12] ? int'(bank_shadow) % int'(DEF_WORK_RAM_BANKS) : 0;
         return 'h10000 + bank * 'h1000 + int'(addr[11:0]);
      end
      if (addr[15:8] == 8'hFE || (addr >= 16'hFF80 && addr <= 16'hFFFE)) begin
         return 'h20000 + int'(addr);
      end
      return -1;
   endfunction

   // Sends one access beat. A read of a RAM byte that holds nothing yet is turned into
   // a write of the same byte. Idle cycles before the beat carry random junk on the bus
   // with tvalid low, which the block must ignore.
   task automatic issue_access(input logic wr, input logic [15:0] addr,
                               input logic [7:0] data, input logic vb);
      int key;
      key = ram_cell_key(addr, vb);
      if (!wr && key >= 0 && !written_cells.exists(key)) wr = 1'b1;
      if (wr && key >= 0) begin
         written_cells[key] = 1'b1;
         written_spots.push_back({vb, addr});
         if (written_spots.size() > 64) void'(written_spots.pop_front());
      end
      if (wr && addr == ADDR_SVBK) begin
         bank_shadow = (data[2:0] == 3'd0) ? 3'd1 : data[2:0];
      end
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, vb, data, addr};
      req_tuser  <= wr;
      do @(posedge clock); while (!req_tready);
   endtask

   // One random access. Most of them land on the local stores and the I/O page, where
   // the interesting decoding lives; a good share reads back bytes written earlier,
   // sometimes through the echo area.
   task automatic random_access();
      int unsigned pick;
      logic        wr;
      logic [15:0] addr;
      logic [7:0]  data;
      logic        vb;
      logic [16:0] spot;
      pick = $urandom_range(99);
      wr   = 1'($urandom_range(1));
      data = 8'($urandom);
      vb   = 1'($urandom_range(1));
      if (pick < 15) begin
         addr = 16'($urandom);
      end else if (pick < 35) begin
         addr = {8'hFF, 8'($urandom)};
      end else if (pick < 45) begin
         addr = {8'hFE, 8'($urandom)};
      end else if (pick < 55) begin
         addr = 16'h8000 + 16'($urandom_range(16'h1FFF));
      end else if (pick < 68) begin
         addr = 16'hC000 + 16'($urandom_range(16'h3DFF));
      end else if (pick < 73 || written_spots.size() == 0) begin
         // Bank select traffic, so the switchable work RAM half moves around.
         addr = ADDR_SVBK;
      end else begin
         spot = written_spots[$urandom_range(written_spots.size() - 1)];
         addr = spot[15:0];
         vb   = spot[16];
         wr   = ($urandom_range(4) == 0);
         if (addr >= 16'hC000 && addr <= 16'hFDFF && $urandom_range(1)) begin
            addr[13] = ~addr[13];   // hop between work RAM and its echo (DE00-DFFF lands on FE00-FFFF)
         end
      end
      issue_access(wr, addr, data, vb);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed beats. Bank select: writing zero must select bank 1, and only the low
      // three bits count.
      issue_access(1'b1, ADDR_SVBK, 8'h00, 1'b0);
      issue_access(1'b0, ADDR_SVBK, 8'h00, 1'b0);
      issue_access(1'b1, 16'hD123, 8'h3C, 1'b0);
      issue_access(1'b1, ADDR_SVBK, 8'hFF, 1'b0);
      issue_access(1'b0, ADDR_SVBK, 8'h00, 1'b0);
      // The same offset in bank 7, read back through the echo area.
      issue_access(1'b1, 16'hD123, 8'hC3, 1'b0);
      issue_access(1'b0, 16'hF123, 8'h00, 1'b0);
      issue_access(1'b1, ADDR_SVBK, 8'h08, 1'b0);
      issue_access(1'b0, 16'hD123, 8'h00, 1'b0);
      // Work RAM boundaries and their echoes.
      issue_access(1'b1, 16'hC000, 8'h00, 1'b0);
      issue_access(1'b0, 16'hE000, 8'h00, 1'b1);
      issue_access(1'b1, 16'hFDFF, 8'hFF, 1'b1);
      issue_access(1'b0, 16'hDDFF, 8'h00, 1'b0);
      // Video RAM in both banks.
      issue_access(1'b1, 16'h8000, 8'hA5, 1'b0);
      issue_access(1'b1, 16'h9FFF, 8'h5A, 1'b1);
      issue_access(1'b0, 16'h9FFF, 8'h00, 1'b1);
      // The unusable area, high RAM and the system registers.
      issue_access(1'b1, 16'hFEFF, 8'h11, 1'b0);
      issue_access(1'b0, 16'hFEFF, 8'h00, 1'b0);
      issue_access(1'b1, 16'hFFFE, 8'h22, 1'b0);
      issue_access(1'b0, ADDR_IE, 8'h00, 1'b0);
      issue_access(1'b1, ADDR_IF, 8'h1F, 1'b0);
      issue_access(1'b0, ADDR_KEY1, 8'h00, 1'b0);
      // The fixed register ignores writes and reads all ones; undecoded I/O reads zero.
      issue_access(1'b1, ADDR_FIXED, 8'h00, 1'b0);
      issue_access(1'b0, ADDR_FIXED, 8'h00, 1'b0);
      issue_access(1'b0, 16'hFF7F, 8'h00, 1'b0);
      // The cartridge unit; random traffic covers the rest of the I/O page.
      issue_access(1'b0, 16'h7FFF, 8'h00, 1'b0);
      issue_access(1'b1, 16'hA000, 8'h77, 1'b1);

      // Random traffic in three pressure phases.
      repeat (400) random_access();
      send_idle_pct = 57;
      recv_idle_pct = 32;
      repeat (400) random_access();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (400) random_access();

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain, then give the two-stage pipeline time to show any stray beat.
      while (results_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && results_pending == 0) begin
         $display("banked_memory_map_decoder_tb: PASS");
      end else begin
         $display("banked_memory_map_decoder_tb: FAIL");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      #10ms;
      $display("banked_memory_map_decoder_tb: FAIL");
      $finish;
   end

endmodule
